>>> rtl/calibration_record_checker_defines.svh
// Assertion macros shared by the record checker's assertion file.
`ifndef CALIBRATION_RECORD_CHECKER_DEFINES_SVH
`define CALIBRATION_RECORD_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CALREC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calrec: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define CALREC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calrec: next-cycle check failed");

`endif

>>> rtl/calrec_pkg.sv
`timescale 1ns / 1ps
package calrec_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_CRC     = 3'd3,
    ST_RANGE       = 3'd4
  } calrec_status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_NODE_MIN  = 3'd0,
    CFG_NODE_MAX  = 3'd1,
    CFG_POLE_MIN  = 3'd2,
    CFG_POLE_MAX  = 3'd3,
    CFG_ZERO_BITS = 3'd4
  } calrec_cfg_t;

  localparam logic [31:0] REC_MAGIC = 32'h5948_4A4D;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

  localparam logic [15:0] VER_1 = 16'd1;
  localparam logic [15:0] VER_2 = 16'd2;
  localparam logic [15:0] VER_3 = 16'd3;

  localparam logic [3:0] CRC_AT_SHORT = 4'd7;
  localparam logic [3:0] CRC_AT_LONG  = 4'd9;

  // Contribution of one input bit to a 32-bit reflected CRC step,
  // evaluated on constants only
  function automatic logic [31:0] crc_column(input int unsigned bit_pos);
    logic [31:0] c;
    c = 32'd1 << bit_pos;
    for (int k = 0; k < 32; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/calibration_record_checker.sv
`timescale 1ns / 1ps
// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
// rec      | rec_valid, rec_ready, record_word, first_word  | in
// res      | res_valid, res_ready, status and record fields | out
//
// One record word is taken per cycle unless stalled by a held result; the transfer loads the
// input register, which then feeds the result register (CRC step and checks).
// The CRC word update is a single XOR network over the 32 bits of the word.
// Reset (rst, synchronous) waits for a word marked first_word.
// A held result stalls the input register, which then stalls rec_ready.
module calibration_record_checker
  import calrec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  logic [31:0]        record_word,
  input  logic               first_word,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [2:0]         status,
  output logic [15:0]        version_seen,
  output logic [7:0]         pole_pairs_out,
  output logic signed [7:0]  encoder_direction,
  output logic signed [7:0]  loop_direction,
  output logic [31:0]        offset_angle_bits,
  output logic [31:0]        zero_angle_bits,
  output logic [7:0]         node_number,
  output logic               gains_present,
  output logic [31:0]        velocity_gains,
  output logic [31:0]        position_gains,
  output logic [15:0]        position_derivative_gain
);

  // Configuration registers
  logic [7:0]  node_min, node_max, pole_min, pole_max;
  logic [31:0] default_zero_bits;

  // Input register
  logic        s1_valid;
  logic [31:0] s1_word;
  logic        s1_first;
  logic        s1_adv;
  logic        fire;

  // Record state
  logic [3:0]  word_index, word_index_next;
  logic [31:0] running_crc, running_crc_next;
  logic        magic_good, magic_good_next;
  logic [31:0] header_word, header_word_next;
  logic [31:0] direction_word, direction_word_next;
  logic [31:0] offset_word, offset_word_next;
  logic [31:0] reserved_words [3];
  logic [31:0] stored_zero_word, stored_zero_word_next;
  logic        record_finished, record_finished_next;

  // Working values for the word in the input register
  logic [3:0]  cur_idx;
  logic [31:0] cur_crc;
  logic        cur_fin;
  logic [15:0] cur_ver;
  logic [3:0]  crc_at;
  logic [31:0] crc_in;
  logic [31:0] crc_terms [32];
  logic [31:0] crc_step;
  logic [15:0] w_ver;
  logic [7:0]  pp, nid;
  logic        dir_good;
  logic        res_load;
  logic [2:0]  st_next;

  // Result register payload
  logic [15:0] ver_next;
  logic [7:0]  pp_next, enc_next, loop_next, node_next, ppd_dummy;
  logic [31:0] off_next, zero_next, vel_next, pos_next;
  logic        gp_next;
  logic [15:0] kd_next;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !res_valid || res_ready;
  assign rec_ready = !s1_valid || s1_adv;
  assign fire      = s1_valid && s1_adv;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      node_min          <= 8'd1;
      node_max          <= 8'd127;
      pole_min          <= 8'd1;
      pole_max          <= 8'd50;
      default_zero_bits <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NODE_MIN:  node_min          <= cfg_data[7:0];
        CFG_NODE_MAX:  node_max          <= cfg_data[7:0];
        CFG_POLE_MIN:  pole_min          <= cfg_data[7:0];
        CFG_POLE_MAX:  pole_max          <= cfg_data[7:0];
        CFG_ZERO_BITS: default_zero_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted word until the result side can take its outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rec_ready) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      s1_word  <= record_word;
      s1_first <= first_word;
    end
  end

  // One 32-bit CRC step as a fixed XOR network
  assign crc_in = cur_crc ^ s1_word;

  for (genvar i = 0; i < 32; i++) begin : g_crc
    localparam logic [31:0] COL = crc_column(i);
    assign crc_terms[i] = crc_in[i] ? COL : 32'd0;
  end

  always_comb begin
    crc_step = '0;
    for (int i = 0; i < 32; i++) begin
      crc_step = crc_step ^ crc_terms[i];
    end
  end

  // A marked first word restarts the record
  assign cur_idx = s1_first ? 4'd0 : word_index;
  assign cur_crc = s1_first ? CRC_INIT : running_crc;
  assign cur_fin = s1_first ? 1'b0 : record_finished;
  assign cur_ver = header_word[15:0];
  assign crc_at  = (cur_ver == VER_3) ? CRC_AT_LONG : CRC_AT_SHORT;
  assign w_ver   = s1_word[15:0];
  assign pp      = header_word[23:16];
  assign nid     = reserved_words[0][7:0];
  assign dir_good = (direction_word[7:0] inside {8'h01, 8'hFF}) &&
                    (direction_word[23:16] inside {8'h01, 8'hFF});
  assign ppd_dummy = '0;

  // Advance the record and form the result
  always_comb begin
    word_index_next       = word_index;
    running_crc_next      = running_crc;
    magic_good_next       = magic_good;
    header_word_next      = header_word;
    direction_word_next   = direction_word;
    offset_word_next      = offset_word;
    stored_zero_word_next = stored_zero_word;
    record_finished_next  = record_finished;
    res_load  = 1'b0;
    st_next   = ST_OK;
    ver_next  = cur_ver;
    pp_next   = ppd_dummy;
    enc_next  = '0;
    loop_next = '0;
    off_next  = '0;
    zero_next = '0;
    node_next = '0;
    gp_next   = 1'b0;
    vel_next  = '0;
    pos_next  = '0;
    kd_next   = '0;

    if (fire) begin
      word_index_next      = cur_idx;
      running_crc_next     = cur_crc;
      record_finished_next = cur_fin;
      if (!cur_fin) begin
        if (cur_idx >= 4'd2 && cur_idx == crc_at) begin
          // CRC word: report the record
          res_load             = 1'b1;
          record_finished_next = 1'b1;
          if (!magic_good) begin
            st_next = ST_BAD_MAGIC;
          end else if (s1_word != ~running_crc) begin
            st_next = ST_BAD_CRC;
          end else if (pp < pole_min || pp > pole_max || !dir_good) begin
            st_next = ST_RANGE;
          end else begin
            st_next = ST_OK;
          end
          if (st_next == ST_OK || st_next == ST_RANGE) begin
            pp_next   = pp;
            enc_next  = direction_word[7:0];
            loop_next = direction_word[23:16];
            off_next  = offset_word;
            zero_next = (cur_ver == VER_3) ? stored_zero_word : default_zero_bits;
            node_next = (nid >= node_min && nid <= node_max) ? nid : 8'd0;
            if (cur_ver >= VER_2) begin
              gp_next  = reserved_words[0][8];
              vel_next = reserved_words[1];
              pos_next = reserved_words[2];
              kd_next  = reserved_words[0][31:16];
            end
          end
        end else begin
          // Data word: fold into the CRC, check the magic word and keep the field words
          running_crc_next = crc_step;
          case (cur_idx)
            4'd0: magic_good_next       = (s1_word == REC_MAGIC);
            4'd1: header_word_next      = s1_word;
            4'd2: direction_word_next   = s1_word;
            4'd3: offset_word_next      = s1_word;
            4'd7: stored_zero_word_next = s1_word;
            default: ;
          endcase
          if (cur_idx == 4'd1 && !(w_ver inside {[VER_1:VER_3]})) begin
            res_load             = 1'b1;
            record_finished_next = 1'b1;
            st_next              = ST_BAD_VERSION;
            ver_next             = w_ver;
          end
          word_index_next = cur_idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index       <= '0;
      running_crc      <= CRC_INIT;
      magic_good       <= 1'b0;
      header_word      <= '0;
      direction_word   <= '0;
      offset_word      <= '0;
      stored_zero_word <= '0;
      record_finished  <= 1'b1;
    end else begin
      word_index       <= word_index_next;
      running_crc      <= running_crc_next;
      magic_good       <= magic_good_next;
      header_word      <= header_word_next;
      direction_word   <= direction_word_next;
      offset_word      <= offset_word_next;
      stored_zero_word <= stored_zero_word_next;
      record_finished  <= record_finished_next;
    end
  end

  // Reserved words are always written before they are read
  always_ff @(posedge clk) begin
    if (fire && !cur_fin && !(cur_idx >= 4'd2 && cur_idx == crc_at)) begin
      case (cur_idx)
        4'd4: reserved_words[0] <= s1_word;
        4'd5: reserved_words[1] <= s1_word;
        4'd6: reserved_words[2] <= s1_word;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status                   <= st_next;
      version_seen             <= ver_next;
      pole_pairs_out           <= pp_next;
      encoder_direction        <= enc_next;
      loop_direction           <= loop_next;
      offset_angle_bits        <= off_next;
      zero_angle_bits          <= zero_next;
      node_number              <= node_next;
      gains_present            <= gp_next;
      velocity_gains           <= vel_next;
      position_gains           <= pos_next;
      position_derivative_gain <= kd_next;
    end
  end

endmodule

>>> rtl/calrec_checker.sv
`timescale 1ns / 1ps
`include "calibration_record_checker_defines.svh"
module calrec_checker
  import calrec_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [2:0]         status,
  input logic [15:0]        version_seen,
  input logic [7:0]         pole_pairs_out,
  input logic signed [7:0]  encoder_direction,
  input logic signed [7:0]  loop_direction,
  input logic [31:0]        offset_angle_bits,
  input logic [31:0]        zero_angle_bits,
  input logic [7:0]         node_number,
  input logic               gains_present,
  input logic [31:0]        velocity_gains,
  input logic [31:0]        position_gains,
  input logic [15:0]        position_derivative_gain
);

  logic fail_rec;
  logic data_rec;
  logic fields_clear;

  assign fail_rec = res_valid && (status == ST_BAD_VERSION || status == ST_BAD_MAGIC ||
                                  status == ST_BAD_CRC);
  assign data_rec = res_valid && (status == ST_OK || status == ST_RANGE);
  assign fields_clear = pole_pairs_out == '0 && encoder_direction == '0 &&
                        loop_direction == '0 && offset_angle_bits == '0 &&
                        zero_angle_bits == '0 && node_number == '0 &&
                        !gains_present && velocity_gains == '0 &&
                        position_gains == '0 && position_derivative_gain == '0;

  // Failed records carry only the version
  `CALREC_ASSERT_NOW(a_fail_clear, fail_rec, fields_clear)

  // A good record has both directions at plus or minus one
  `CALREC_ASSERT_NOW(a_ok_dirs, res_valid && status == ST_OK,
    (encoder_direction == 8'sh01 || encoder_direction == 8'shFF) &&
    (loop_direction == 8'sh01 || loop_direction == 8'shFF))

  // Version 1 records carry no gains
  `CALREC_ASSERT_NOW(a_v1_no_gains, data_rec && version_seen == VER_1,
    !gains_present && velocity_gains == '0 && position_gains == '0 &&
    position_derivative_gain == '0)

  // A stalled result holds its status
  `CALREC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable(status) && $stable(version_seen))

endmodule

bind calibration_record_checker calrec_checker u_calrec_checker (.*);
